### hdl/ffha_pkg.sv
package ffha_pkg;

  localparam int unsigned ADDR_W = 48;
  localparam int unsigned LEN_W  = 41;
  localparam int unsigned LG_W   = 6;
  localparam int unsigned MAGIC_W = 64;
  localparam int unsigned ST_W   = 3;
  localparam int unsigned CALC_W = 50;

  localparam int unsigned FREE_ENTRIES_DEF = 64;
  localparam int unsigned SPLIT_MIN_DEF    = 64;

  localparam logic [MAGIC_W-1:0] HEAP_MAGIC  = 64'h5043_5835_4845_4150;
  localparam logic [ADDR_W-1:0]  HDR_BYTES   = 48'd16;
  localparam logic [LG_W-1:0]    MIN_ALIGN_LG = 6'd4;
  localparam logic [LG_W-1:0]    BIG_ALIGN_LG = 6'd48;
  localparam logic [ADDR_W-1:0]  ADDR_MAX    = {ADDR_W{1'b1}};
  localparam logic [LEN_W-1:0]   LEN_MAX     = {LEN_W{1'b1}};
  localparam logic [ADDR_W-1:0]  BASE_RST    = 48'd65536;
  localparam logic [LEN_W-1:0]   SIZE_RST    = 41'd16777216;

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 64;

  typedef enum logic [0:0] {
    REG_ARENA_BASE = 1'b0,
    REG_ARENA_SIZE = 1'b1
  } reg_idx_e;

  typedef enum logic [0:0] {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 3'd0,
    ST_OOM  = 3'd1,
    ST_BAD  = 3'd2,
    ST_FULL = 3'd3,
    ST_NULL = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_SCAN,
    S_ALN,
    S_FIT,
    S_MVRD,
    S_MVWR,
    S_BALN,
    S_BFIT,
    S_FREE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic rd_scan;
    logic rd_next;
    logic calc_align;
    logic align_bump;
    logic idx_inc;
    logic wr_split;
    logic wr_shift;
    logic cnt_dec;
    logic bump_commit;
    logic set_ok;
    logic set_oom;
    logic free_exec;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic idx_lt_cnt;
    logic next_lt_cnt;
    logic fit;
    logic split;
    logic bump_fit;
    logic out_free;
  } stat_t;

endpackage

### hdl/ffha_if.sv
interface ffha_in_if import ffha_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [LEN_W-1:0]   req_size;
  logic [LG_W-1:0]    align_log2;
  logic [ADDR_W-1:0]  block_address;
  logic [MAGIC_W-1:0] header_magic;
  logic [LEN_W-1:0]   header_size;

  modport source (output valid, mode, req_size, align_log2, block_address, header_magic,
                  header_size, input ready);
  modport sink (input valid, mode, req_size, align_log2, block_address, header_magic,
                header_size, output ready);
endinterface

interface ffha_out_if import ffha_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] result_address;
  logic [LEN_W-1:0]  header_user_size;
  logic [ST_W-1:0]   status;

  modport source (output valid, result_address, header_user_size, status, input ready);
  modport sink (input valid, result_address, header_user_size, status, output ready);
endinterface

### hdl/ffha_ram.sv
module ffha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/ffha_ctrl.sv
module ffha_ctrl import ffha_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        state_d = stat_i.is_free ? S_FREE : S_SCAN;
      end
      S_SCAN: begin
        if (stat_i.idx_lt_cnt) begin
          cmd_o.rd_scan = 1'b1;
          state_d       = S_ALN;
        end else begin
          state_d = S_BALN;
        end
      end
      S_ALN: begin
        cmd_o.calc_align = 1'b1;
        state_d          = S_FIT;
      end
      S_FIT: begin
        if (stat_i.fit) begin
          cmd_o.set_ok = 1'b1;
          if (stat_i.split) begin
            cmd_o.wr_split = 1'b1;
            state_d        = S_DONE;
          end else begin
            state_d = S_MVRD;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_SCAN;
        end
      end
      S_MVRD: begin
        if (stat_i.next_lt_cnt) begin
          cmd_o.rd_next = 1'b1;
          state_d       = S_MVWR;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_MVWR: begin
        cmd_o.wr_shift = 1'b1;
        state_d        = S_MVRD;
      end
      S_BALN: begin
        cmd_o.calc_align = 1'b1;
        cmd_o.align_bump = 1'b1;
        state_d          = S_BFIT;
      end
      S_BFIT: begin
        if (stat_i.bump_fit) begin
          cmd_o.bump_commit = 1'b1;
          cmd_o.set_ok      = 1'b1;
        end else begin
          cmd_o.set_oom = 1'b1;
        end
        state_d = S_DONE;
      end
      S_FREE: begin
        cmd_o.free_exec = 1'b1;
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### hdl/ffha_dp.sv
module ffha_dp import ffha_pkg::*; #(
  parameter int unsigned FREE_ENTRIES = FREE_ENTRIES_DEF,
  parameter int unsigned SPLIT_MIN    = SPLIT_MIN_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  input  logic               mode_i,
  input  logic [LEN_W-1:0]   req_size_i,
  input  logic [LG_W-1:0]    align_log2_i,
  input  logic [ADDR_W-1:0]  block_address_i,
  input  logic [MAGIC_W-1:0] header_magic_i,
  input  logic [LEN_W-1:0]   header_size_i,
  input  logic               cfg_we_i,
  input  reg_idx_e           cfg_idx_i,
  input  logic [APB_DW-1:0]  cfg_data_i,
  output logic [ADDR_W-1:0]  arena_base_o,
  output logic [LEN_W-1:0]   arena_size_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [ADDR_W-1:0]  out_addr_o,
  output logic [LEN_W-1:0]   out_size_o,
  output logic [ST_W-1:0]    out_status_o
);

  localparam int unsigned AW = $clog2(FREE_ENTRIES);
  localparam int unsigned CW = $clog2(FREE_ENTRIES + 1);
  localparam int unsigned EW = ADDR_W + LEN_W;

  logic               mode_q;
  logic [LEN_W-1:0]   size_q;
  logic [LG_W-1:0]    lg_q;
  logic [ADDR_W-1:0]  ptr_q;
  logic               magic_ok_q;
  logic [LEN_W-1:0]   hsize_q;
  logic [CALC_W-1:0]  aligned_q;
  logic [ADDR_W-1:0]  ent_start_q;
  logic [LEN_W-1:0]   ent_len_q;
  logic [CW-1:0]      idx_q, cnt_q;
  logic [ADDR_W-1:0]  bump_q, base_q;
  logic [LEN_W-1:0]   asize_q;
  logic [ADDR_W-1:0]  res_addr_q, out_addr_q;
  logic [LEN_W-1:0]   res_size_q, out_size_q;
  status_e            res_st_q, out_st_q;
  logic               out_valid_q;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [EW-1:0]      ram_wdata, ram_rdata;
  logic [ADDR_W-1:0]  rd_start;
  logic [LEN_W-1:0]   rd_len;

  logic [LG_W-1:0]    eff_lg;
  logic               lg_big;
  logic [ADDR_W-1:0]  align_base;
  logic [CALC_W-1:0]  align_one, align_sum, aligned_d;
  logic [CALC_W-1:0]  end_user, total;
  logic [LEN_W-1:0]   rem;
  logic               addr_ok;
  logic [ADDR_W:0]    arena_sum, arena_end;
  logic [CW-1:0]      idx_next;
  logic [LEN_W:0]     free_len_w;
  logic [LEN_W-1:0]   free_len;
  logic               cnt_full;
  status_e            free_st;

  assign {rd_start, rd_len} = ram_rdata;

  assign eff_lg     = (lg_q < MIN_ALIGN_LG) ? MIN_ALIGN_LG : lg_q;
  assign lg_big     = (eff_lg >= BIG_ALIGN_LG);
  assign align_base = cmd_i.align_bump ? bump_q : rd_start;
  assign align_one  = CALC_W'(1) << eff_lg;
  assign align_sum  = CALC_W'(align_base) + CALC_W'(HDR_BYTES) + align_one - CALC_W'(1);
  assign aligned_d  = align_sum & ~(align_one - CALC_W'(1));

  assign end_user = aligned_q + CALC_W'(size_q);
  assign total    = aligned_q - CALC_W'(ent_start_q) + CALC_W'(size_q);
  assign rem      = ent_len_q - total[LEN_W-1:0];
  assign addr_ok  = !lg_big && (end_user <= CALC_W'(ADDR_MAX));

  assign arena_sum = {1'b0, base_q} + (ADDR_W+1)'(asize_q);
  assign arena_end = (arena_sum > (ADDR_W+1)'(ADDR_MAX)) ? (ADDR_W+1)'(ADDR_MAX) : arena_sum;

  assign idx_next = idx_q + CW'(1);
  assign cnt_full = (cnt_q >= CW'(FREE_ENTRIES));

  assign free_len_w = {1'b0, hsize_q} + (LEN_W+1)'(HDR_BYTES);
  assign free_len   = free_len_w[LEN_W] ? LEN_MAX : free_len_w[LEN_W-1:0];

  always_comb begin
    if (ptr_q == '0) begin
      free_st = ST_NULL;
    end else if (ptr_q < HDR_BYTES || !magic_ok_q) begin
      free_st = ST_BAD;
    end else if (cnt_full) begin
      free_st = ST_FULL;
    end else begin
      free_st = ST_OK;
    end
  end

  always_comb begin
    stat_o.is_free     = (mode_q == MODE_FREE);
    stat_o.idx_lt_cnt  = (idx_q < cnt_q);
    stat_o.next_lt_cnt = (idx_next < cnt_q);
    stat_o.fit         = addr_ok && (total <= CALC_W'(ent_len_q));
    stat_o.split       = (rem >= LEN_W'(SPLIT_MIN));
    stat_o.bump_fit    = !lg_big && (end_user <= CALC_W'(arena_end));
    stat_o.out_free    = !out_valid_q || out_ready_i;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q[AW-1:0];
    ram_wdata = ram_rdata;
    if (cmd_i.wr_split) begin
      ram_we    = 1'b1;
      ram_wdata = {end_user[ADDR_W-1:0], rem};
    end else if (cmd_i.wr_shift) begin
      ram_we    = 1'b1;
    end else if (cmd_i.free_exec && free_st == ST_OK) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_q[AW-1:0];
      ram_wdata = {ptr_q - HDR_BYTES, free_len};
    end
  end

  assign ram_re    = cmd_i.rd_scan || cmd_i.rd_next;
  assign ram_raddr = cmd_i.rd_next ? idx_next[AW-1:0] : idx_q[AW-1:0];

  ffha_ram #(
    .WIDTH (EW),
    .DEPTH (FREE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q     <= mode_i;
      size_q     <= (req_size_i == '0) ? LEN_W'(1) : req_size_i;
      lg_q       <= align_log2_i;
      ptr_q      <= block_address_i;
      magic_ok_q <= (header_magic_i == HEAP_MAGIC);
      hsize_q    <= header_size_i;
    end
    if (cmd_i.calc_align) begin
      aligned_q   <= aligned_d;
      ent_start_q <= rd_start;
      ent_len_q   <= rd_len;
    end
    if (cmd_i.set_ok) begin
      res_addr_q <= aligned_q[ADDR_W-1:0];
      res_size_q <= size_q;
      res_st_q   <= ST_OK;
    end else if (cmd_i.set_oom) begin
      res_addr_q <= '0;
      res_size_q <= '0;
      res_st_q   <= ST_OOM;
    end else if (cmd_i.free_exec) begin
      res_addr_q <= '0;
      res_size_q <= '0;
      res_st_q   <= free_st;
    end
    if (cmd_i.out_load) begin
      out_addr_q <= res_addr_q;
      out_size_q <= res_size_q;
      out_st_q   <= res_st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      cnt_q       <= '0;
      bump_q      <= BASE_RST;
      base_q      <= BASE_RST;
      asize_q     <= SIZE_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc || cmd_i.wr_shift) begin
        idx_q <= idx_next;
      end
      if (cmd_i.cnt_dec) begin
        cnt_q <= cnt_q - CW'(1);
      end else if (cmd_i.free_exec && free_st == ST_OK) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (cfg_we_i && cfg_idx_i == REG_ARENA_BASE) begin
        base_q <= cfg_data_i[ADDR_W-1:0];
        bump_q <= cfg_data_i[ADDR_W-1:0];
      end else if (cmd_i.bump_commit) begin
        bump_q <= end_user[ADDR_W-1:0];
      end
      if (cfg_we_i && cfg_idx_i == REG_ARENA_SIZE) begin
        asize_q <= cfg_data_i[LEN_W-1:0];
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign arena_base_o = base_q;
  assign arena_size_o = asize_q;
  assign out_valid_o  = out_valid_q;
  assign out_addr_o   = out_addr_q;
  assign out_size_o   = out_size_q;
  assign out_status_o = out_st_q;

endmodule

### hdl/first_fit_heap_allocator_top.sv
// First-fit heap allocator. One transaction in gives one transaction out. An allocate
// scans the free list in order from a free-list memory with one write port, one read
// port and registered read; removing an entry that is used up moves each later entry
// down by one place. When nothing fits, the bump pointer in the arena is tried instead.
// One transaction is in flight at a time; the result register lets the next
// transaction be taken while the previous result still waits. Registers: arena_base
// at 0x0, arena_size at 0x8; writing arena_base also resets the bump pointer.
module first_fit_heap_allocator_top import ffha_pkg::*; #(
  parameter int unsigned FREE_ENTRIES = FREE_ENTRIES_DEF,
  parameter int unsigned SPLIT_MIN    = SPLIT_MIN_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ffha_in_if.sink           in_i,
  ffha_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cmd_t              cmd;
  stat_t             stat;
  logic              cfg_we;
  reg_idx_e          cfg_idx;
  logic [ADDR_W-1:0] arena_base;
  logic [LEN_W-1:0]  arena_size;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3]);
  assign prdata  = (cfg_idx == REG_ARENA_BASE) ? APB_DW'(arena_base) : APB_DW'(arena_size);

  ffha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ffha_dp #(
    .FREE_ENTRIES (FREE_ENTRIES),
    .SPLIT_MIN    (SPLIT_MIN)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .mode_i          (in_i.mode),
    .req_size_i      (in_i.req_size),
    .align_log2_i    (in_i.align_log2),
    .block_address_i (in_i.block_address),
    .header_magic_i  (in_i.header_magic),
    .header_size_i   (in_i.header_size),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (pwdata),
    .arena_base_o    (arena_base),
    .arena_size_o    (arena_size),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .out_addr_o      (out_o.result_address),
    .out_size_o      (out_o.header_user_size),
    .out_status_o    (out_o.status)
  );

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("transaction accepted while another is in flight");

  a_ok_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == ST_OK && out_o.result_address != '0)
      |-> (out_o.result_address[3:0] == 4'd0 && out_o.header_user_size != '0))
    else $error("allocated pointer not 16-byte aligned or zero size");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != ST_OK)
      |-> (out_o.result_address == '0 && out_o.header_user_size == '0))
    else $error("failed transaction carries non-zero result");

endmodule

### sim/tb_top.sv
module tb_top;
  import ffha_pkg::*;

  localparam int unsigned LIST_DEPTH  = 64;
  localparam int unsigned SPLIT_BYTES = 64;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS = 265;

  typedef struct {
    mode_e              mode;
    logic [LEN_W-1:0]   req_size;
    logic [LG_W-1:0]    align_log2;
    logic [ADDR_W-1:0]  block_address;
    logic [MAGIC_W-1:0] header_magic;
    logic [LEN_W-1:0]   header_size;
  } heap_req_t;

  typedef struct {
    logic [ADDR_W-1:0] result_address;
    logic [LEN_W-1:0]  header_user_size;
    status_e           status;
  } heap_res_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ffha_in_if  in_if ();
  ffha_out_if out_if ();

  logic              psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  first_fit_heap_allocator_top u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [63:0] arena_base_q, arena_size_q, bump_q;
  logic [63:0] list_start[LIST_DEPTH];
  logic [63:0] list_len[LIST_DEPTH];
  int unsigned list_cnt;

  heap_req_t pend_q[$];
  heap_res_t alloc_exp_q[$];
  heap_req_t cur_req;
  int unsigned gap_cnt, drv_gap;
  int unsigned rdy_wait, hold_cnt;
  logic        hold_go, hold_done, no_idle;
  int unsigned fail_cnt, cyc_cnt;
  int unsigned st_seen[5];

  function automatic void heap_predict(input heap_req_t r, output heap_res_t e);
    logic [63:0] sz, al, aligned, total, top;
    int unsigned lg, i, j;
    bit hit;
    e.result_address   = '0;
    e.header_user_size = '0;
    e.status           = ST_OK;
    if (r.mode == MODE_ALLOC) begin
      sz = 64'(r.req_size);
      if (sz == 64'd0) sz = 64'd1;
      lg = 32'(r.align_log2);
      if (lg < 32'(MIN_ALIGN_LG)) lg = 32'(MIN_ALIGN_LG);
      al = 64'd1 << lg;
      hit = 1'b0;
      for (i = 0; i < list_cnt && !hit; i++) begin
        aligned = (list_start[i] + 64'd16 + al - 64'd1) & ~(al - 64'd1);
        total = (aligned - list_start[i]) + sz;
        if (!(total > list_len[i] || aligned + sz > 64'(ADDR_MAX))) begin
          hit = 1'b1;
          if (list_len[i] - total >= 64'(SPLIT_BYTES)) begin
            list_start[i] += total;
            list_len[i]   -= total;
          end else begin
            for (j = i; j + 1 < list_cnt; j++) begin
              list_start[j] = list_start[j+1];
              list_len[j]   = list_len[j+1];
            end
            list_cnt--;
          end
          e.result_address   = aligned[ADDR_W-1:0];
          e.header_user_size = sz[LEN_W-1:0];
        end
      end
      if (!hit) begin
        top = arena_base_q + arena_size_q;
        if (top > 64'(ADDR_MAX)) top = 64'(ADDR_MAX);
        aligned = (bump_q + 64'd16 + al - 64'd1) & ~(al - 64'd1);
        total = (aligned - bump_q) + sz;
        if (bump_q + total <= top) begin
          bump_q += total;
          e.result_address   = aligned[ADDR_W-1:0];
          e.header_user_size = sz[LEN_W-1:0];
        end else begin
          e.status = ST_OOM;
        end
      end
    end else begin
      if (r.block_address == '0) begin
        e.status = ST_NULL;
      end else if (r.block_address < HDR_BYTES || r.header_magic != HEAP_MAGIC) begin
        e.status = ST_BAD;
      end else if (list_cnt >= LIST_DEPTH) begin
        e.status = ST_FULL;
      end else begin
        total = 64'(r.header_size) + 64'd16;
        if (total > 64'(LEN_MAX)) total = 64'(LEN_MAX);
        list_start[list_cnt] = 64'(r.block_address) - 64'd16;
        list_len[list_cnt]   = total;
        list_cnt++;
      end
    end
  endfunction

  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic void add_req(input heap_req_t r);
    pend_q.insert(pend_q.size(), r);
  endfunction

  task automatic present(input heap_req_t r);
    in_if.mode          <= r.mode;
    in_if.req_size      <= r.req_size;
    in_if.align_log2    <= r.align_log2;
    in_if.block_address <= r.block_address;
    in_if.header_magic  <= r.header_magic;
    in_if.header_size   <= r.header_size;
  endtask

  // driver
  always @(posedge clk_i) begin
    heap_res_t e;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        heap_predict(cur_req, e);
        alloc_exp_q.insert(alloc_exp_q.size(), e);
        drv_gap = draw_gap();
        if (drv_gap == 0 && pend_q.size() > 0) begin
          cur_req = pend_q.pop_front();
          present(cur_req);
        end else begin
          in_if.valid <= 1'b0;
          gap_cnt <= drv_gap;
        end
      end else if (!in_if.valid) begin
        if (gap_cnt > 0) begin
          gap_cnt <= gap_cnt - 1;
        end else if (pend_q.size() > 0) begin
          cur_req = pend_q.pop_front();
          present(cur_req);
          in_if.valid <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    heap_res_t e;
    int unsigned w;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (alloc_exp_q.size() == 0) begin
          $error("unexpected result transaction");
          fail_cnt++;
        end else begin
          e = alloc_exp_q.pop_front();
          if (out_if.status < 5) st_seen[out_if.status]++;
          if (out_if.result_address !== e.result_address) begin
            $error("result_address expected %h got %h", e.result_address,
                   out_if.result_address);
            fail_cnt++;
          end
          if (out_if.header_user_size !== e.header_user_size) begin
            $error("header_user_size expected %h got %h", e.header_user_size,
                   out_if.header_user_size);
            fail_cnt++;
          end
          if (out_if.status !== e.status) begin
            $error("status expected %0d got %0d", e.status, out_if.status);
            fail_cnt++;
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_if.ready <= (hold_cnt == 1);
      end else if (hold_go && !hold_done) begin
        hold_cnt <= HOLD_CYCLES;
        hold_done <= 1'b1;
        out_if.ready <= 1'b0;
      end else if (out_if.valid && out_if.ready) begin
        w = draw_gap();
        rdy_wait <= w;
        out_if.ready <= (w == 0);
      end else if (!out_if.ready) begin
        if (rdy_wait > 0) rdy_wait <= rdy_wait - 1;
        else out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic cfg_write(input reg_idx_e idx, input logic [63:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(idx) << 3;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_ARENA_BASE) begin
      arena_base_q = val & 64'(ADDR_MAX);
      bump_q = arena_base_q;
    end else begin
      arena_size_q = val & 64'(LEN_MAX);
    end
  endtask

  // sampled away from the rising edge so that driver updates have settled
  task automatic drain();
    while (pend_q.size() > 0 || in_if.valid || alloc_exp_q.size() > 0) @(negedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic heap_req_t mk_req(input mode_e m, input logic [LEN_W-1:0] sz,
                                       input logic [LG_W-1:0] lg,
                                       input logic [ADDR_W-1:0] ptr,
                                       input logic [MAGIC_W-1:0] mg,
                                       input logic [LEN_W-1:0] hs);
    heap_req_t r;
    r.mode = m; r.req_size = sz; r.align_log2 = lg;
    r.block_address = ptr; r.header_magic = mg; r.header_size = hs;
    return r;
  endfunction

  function automatic heap_req_t rand_req(input int unsigned free_pct);
    heap_req_t r;
    int unsigned k;
    r.mode          = ($urandom_range(0, 99) < free_pct) ? MODE_FREE : MODE_ALLOC;
    r.align_log2    = 6'($urandom);
    r.req_size      = 41'({$urandom, $urandom});
    r.block_address = 48'({$urandom, $urandom});
    r.header_magic  = {$urandom, $urandom};
    r.header_size   = 41'({$urandom, $urandom});
    k = $urandom_range(0, 99);
    if (k < 70) r.req_size = 41'($urandom_range(0, 200));
    else if (k < 90) r.req_size = 41'($urandom_range(0, 4096));
    else if (k < 95) r.req_size = 41'($urandom_range(0, 1 << 24));
    else if (k < 97) r.req_size = 41'd1 << 40;
    else r.req_size = r.req_size & ~(41'd1 << 40);
    k = $urandom_range(0, 99);
    if (k < 80) r.align_log2 = 6'($urandom_range(0, 8));
    else if (k < 95) r.align_log2 = 6'($urandom_range(0, 32));
    k = $urandom_range(0, 99);
    if (k < 4) r.block_address = '0;
    else if (k < 8) r.block_address = 48'($urandom_range(1, 15));
    else if (k < 90) r.block_address = 48'(arena_base_q) + 48'($urandom_range(16, 1 << 20));
    k = $urandom_range(0, 99);
    if (k < 90) r.header_magic = HEAP_MAGIC;
    else if (k < 95) r.header_magic = HEAP_MAGIC ^ (64'd1 << $urandom_range(0, 63));
    k = $urandom_range(0, 99);
    if (k < 80) r.header_size = 41'($urandom_range(0, 300));
    else if (k < 97) r.header_size = 41'($urandom_range(0, 1 << 20));
    return r;
  endfunction

  task automatic run_phase(input int unsigned free_pct, input bit with_hold);
    int unsigned n;
    for (n = 0; n < PHASE_ITEMS; n++) add_req(rand_req(free_pct));
    if (with_hold) begin
      while (pend_q.size() > PHASE_ITEMS / 2) @(posedge clk_i);
      hold_go <= 1'b1;
    end
    while (pend_q.size() > PHASE_ITEMS / 2) @(posedge clk_i);
    no_idle <= ~no_idle;
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0; in_if.mode = MODE_ALLOC; in_if.req_size = '0;
    in_if.align_log2 = '0; in_if.block_address = '0; in_if.header_magic = '0;
    in_if.header_size = '0;
    out_if.ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    gap_cnt = 0; rdy_wait = 0; hold_cnt = 0;
    hold_go = 1'b0; hold_done = 1'b0; no_idle = 1'b0;
    fail_cnt = 0; cyc_cnt = 0;
    foreach (st_seen[i]) st_seen[i] = 0;
    arena_base_q = 64'(BASE_RST);
    arena_size_q = 64'(SIZE_RST);
    bump_q = arena_base_q;
    list_cnt = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner cases on reset settings
    add_req(mk_req(MODE_ALLOC, '0, '0, '0, '0, '0));
    add_req(mk_req(MODE_ALLOC, 41'd1, 6'd63, '0, '0, '0));
    add_req(mk_req(MODE_ALLOC, 41'd1 << 40, 6'd32, '0, '0, '0));
    add_req(mk_req(MODE_FREE, '0, '0, '0, HEAP_MAGIC, '0));
    add_req(mk_req(MODE_FREE, '0, '0, 48'd8, HEAP_MAGIC, '0));
    add_req(mk_req(MODE_FREE, '0, '0, 48'h20000, ~HEAP_MAGIC, '0));
    add_req(mk_req(MODE_FREE, '0, '0, ADDR_MAX, HEAP_MAGIC, LEN_MAX));
    add_req(mk_req(MODE_FREE, '0, '0, 48'h20000, HEAP_MAGIC, 41'd100));
    add_req(mk_req(MODE_ALLOC, 41'd40, 6'd2, '0, '0, '0));
    add_req(mk_req(MODE_FREE, '0, '0, 48'h30000, HEAP_MAGIC, 41'd200));
    add_req(mk_req(MODE_ALLOC, 41'd10, 6'd4, '0, '0, '0));
    add_req(mk_req(MODE_ALLOC, 41'd1, 6'd5, '0, '0, '0));
    add_req(mk_req(MODE_FREE, '0, '0, 48'h40010, HEAP_MAGIC, '0));
    add_req(mk_req(MODE_ALLOC, 41'd1, '0, '0, '0, '0));
    add_req(mk_req(MODE_ALLOC, 41'h1FFFFFFFFFF, 6'h3F, '0, '0, '0));
    add_req(mk_req(MODE_FREE, '0, '0, 48'hFFFFFFFF0000, 64'hFFFFFFFFFFFFFFFF,
                   41'h1FFFFFFFFFF));
    drain();

    run_phase(50, 1'b1);
    cfg_write(REG_ARENA_BASE, 64'h1000);
    cfg_write(REG_ARENA_SIZE, 64'd4096);
    run_phase(85, 1'b0);
    cfg_write(REG_ARENA_BASE, 64'(ADDR_MAX) - 64'h10000);
    cfg_write(REG_ARENA_SIZE, 64'(LEN_MAX));
    run_phase(40, 1'b0);
    cfg_write(REG_ARENA_BASE, 64'd0);
    cfg_write(REG_ARENA_SIZE, 64'd0);
    run_phase(50, 1'b0);
    cfg_write(REG_ARENA_BASE, 64'($urandom) << 12);
    cfg_write(REG_ARENA_SIZE, 64'd1 << 24);
    run_phase(50, 1'b0);

    $display("Covered allocate/free mix over five arena settings incl. long output stall.");
    $display("Statuses seen: ok %0d oom %0d bad %0d full %0d null %0d",
             st_seen[0], st_seen[1], st_seen[2], st_seen[3], st_seen[4]);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
